// ----- rtl/core/ttvg_pkg.sv -----
// Shared constants, types and color helpers of the tile text video generator.
package ttvg_pkg;

    localparam int DEF_TILE_COLUMNS = 40;
    localparam int DEF_SCAN_LINES   = 240;

    localparam int FONT_CELLS = 2048;
    localparam int FONT_AW    = 11;

    // Upper five address bits select the store, lower eleven the entry.
    localparam logic [4:0] FONT_TAG = 5'h1E;
    localparam logic [4:0] MAP_TAG  = 5'h1F;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_rgb RGB_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam t_rgb RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};

    localparam t_rgb PALETTE [6] = '{
        '{red: 8'd0,   green: 8'd255, blue: 8'd0},
        '{red: 8'd255, green: 8'd0,   blue: 8'd0},
        '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
        '{red: 8'd255, green: 8'd255, blue: 8'd0},
        '{red: 8'd0,   green: 8'd255, blue: 8'd255},
        '{red: 8'd255, green: 8'd0,   blue: 8'd255}
    };

    // Foreground of a tile: palette for tiles 8..31, white otherwise.
    function automatic t_rgb fg_color(input logic [7:0] tile);
        logic [4:0] v;
        t_rgb       c;
        v = tile[4:0] - 5'd8;
        if (v >= 5'd18) begin
            v = v - 5'd18;
        end else if (v >= 5'd12) begin
            v = v - 5'd12;
        end else if (v >= 5'd6) begin
            v = v - 5'd6;
        end
        if (tile >= 8'd8 && tile < 8'd32) begin
            c = PALETTE[v[2:0]];
        end else begin
            c = RGB_WHITE;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/ttvg_in_if.sv -----
// Request channel: CPU writes and pixel ticks.
interface ttvg_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output func, output address, output write_data,
                    input ready);
    modport sink   (input valid, input func, input address, input write_data,
                    output ready);
endinterface

// ----- rtl/core/ttvg_out_if.sv -----
// Pixel channel: one colored pixel with its raster position.
interface ttvg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic       line_end;
    logic       frame_end;

    modport source (output valid, output red, output green, output blue,
                    output pixel_x, output pixel_y, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input pixel_x, input pixel_y, input line_end, input frame_end,
                    output ready);
endinterface

// ----- rtl/core/tile_text_video_generator_core.sv -----
// Character-mode tile video generator: stores, raster beam and pixel pipeline.
//
// i_req carries requests: func = FUNC_WRITE stores write_data into the font
// store (0xF000..0xF7FF) or the character map (0xF800 onward, one byte per
// tile cell); other addresses are dropped. Writes give no pixel.
// func = FUNC_PIXEL renders the pixel under the beam and moves the beam on
// in raster order, wrapping to (0,0) after the last pixel of the frame.
// o_pix returns one pixel per tick with its position and end-of-line and
// end-of-frame flags.
// Throughput: one request per cycle while o_pix is not stalled and no clearing
// pass runs; the character-map read, font read and color register form three
// stages that an accepted tick passes in that order before it shows on o_pix.
// Reset: a clearing pass zeroes both stores, one entry per cycle, with
// i_req.ready low; the beam starts at (0,0).
// Stall: when o_pix.ready is low, pipeline bubbles still fill, so up to three
// pixels are held before i_req.ready drops.
module tile_text_video_generator_core #(
    parameter int TILE_COLUMNS = ttvg_pkg::DEF_TILE_COLUMNS,
    parameter int SCAN_LINES   = ttvg_pkg::DEF_SCAN_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ttvg_in_if.sink           i_req,
    ttvg_out_if.source        o_pix
);
    import ttvg_pkg::*;

    localparam int TILE_ROWS   = (SCAN_LINES + 7) / 8;
    localparam int MAP_CELLS   = TILE_COLUMNS * TILE_ROWS;
    localparam int MAP_AW      = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam int LINE_PIXELS = TILE_COLUMNS * 8;
    localparam int CELL_W      = 12;

    localparam logic [8:0]        LAST_X   = 9'(LINE_PIXELS - 1);
    localparam logic [7:0]        LAST_Y   = 8'(SCAN_LINES - 1);
    localparam logic [CELL_W-1:0] MAP_LIM  = CELL_W'(MAP_CELLS);
    localparam logic [FONT_AW-1:0] CLR_LAST = FONT_AW'(FONT_CELLS - 1);

    logic [7:0] map_mem  [MAP_CELLS];
    logic [7:0] font_mem [FONT_CELLS];

    logic               r_clearing;
    logic [FONT_AW-1:0] r_clr_cnt;

    logic [8:0] r_beam_x, n_beam_x;
    logic [7:0] r_beam_y, n_beam_y;

    // stage 1: tile read
    logic       r_s1_valid;
    logic [7:0] r_s1_tile;
    logic [8:0] r_s1_x;
    logic [7:0] r_s1_y;
    logic       r_s1_lend;
    logic       r_s1_fend;
    // stage 2: font row read
    logic       r_s2_valid;
    logic [7:0] r_s2_tile;
    logic [7:0] r_s2_row;
    logic [8:0] r_s2_x;
    logic [7:0] r_s2_y;
    logic       r_s2_lend;
    logic       r_s2_fend;
    // output register
    logic       r_o_valid;
    t_rgb       r_o_rgb;
    logic [8:0] r_o_x;
    logic [7:0] r_o_y;
    logic       r_o_lend;
    logic       r_o_fend;

    logic o_adv, s2_adv, s1_adv;
    logic req_acc, pix_acc, wr_acc;
    logic font_hit, map_hit, font_wr, map_wr;
    logic last_px, last_ln;
    logic [CELL_W-1:0]  cell_full;
    logic [MAP_AW-1:0]  map_rd_idx;
    logic [FONT_AW-1:0] font_rd_addr;
    logic               map_clr;
    t_rgb               fg;

    assign o_adv  = r_s2_valid && (!r_o_valid || o_pix.ready);
    assign s2_adv = r_s1_valid && (!r_s2_valid || o_adv);
    assign s1_adv = s2_adv;

    // font writes must not pass a pixel whose font read is still pending
    assign i_req.ready = !r_clearing && (!r_s1_valid || s1_adv);

    assign req_acc = i_req.valid && i_req.ready;
    assign pix_acc = req_acc && (i_req.func == FUNC_PIXEL);
    assign wr_acc  = req_acc && (i_req.func == FUNC_WRITE);

    assign font_hit = (i_req.address[15:11] == FONT_TAG);
    assign map_hit  = (i_req.address[15:11] == MAP_TAG)
                   && ({1'b0, i_req.address[10:0]} < MAP_LIM);
    assign font_wr  = wr_acc && font_hit;
    assign map_wr   = wr_acc && map_hit;

    assign last_px = (r_beam_x == LAST_X);
    assign last_ln = (r_beam_y == LAST_Y);

    assign cell_full  = CELL_W'(r_beam_y[7:3]) * CELL_W'(TILE_COLUMNS)
                      + CELL_W'(r_beam_x[8:3]);
    assign map_rd_idx = cell_full[MAP_AW-1:0];

    assign font_rd_addr = {r_s1_tile, r_s1_y[2:0]};
    assign map_clr      = r_clearing && ({1'b0, r_clr_cnt} < MAP_LIM);
    assign fg           = fg_color(r_s2_tile);

    always_comb begin
        n_beam_x = r_beam_x;
        n_beam_y = r_beam_y;
        if (pix_acc) begin
            if (last_px) begin
                n_beam_x = '0;
                n_beam_y = last_ln ? 8'd0 : r_beam_y + 8'd1;
            end else begin
                n_beam_x = r_beam_x + 9'd1;
            end
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (map_clr) begin
            map_mem[r_clr_cnt[MAP_AW-1:0]] <= '0;
        end else if (map_wr) begin
            map_mem[i_req.address[MAP_AW-1:0]] <= i_req.write_data;
        end
        if (pix_acc) begin
            r_s1_tile <= map_mem[map_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            font_mem[r_clr_cnt] <= '0;
        end else if (font_wr) begin
            font_mem[i_req.address[FONT_AW-1:0]] <= i_req.write_data;
        end
        if (s1_adv) begin
            r_s2_row <= font_mem[font_rd_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_beam_x   <= '0;
            r_beam_y   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            r_beam_x <= n_beam_x;
            r_beam_y <= n_beam_y;
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (o_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_x    <= r_beam_x;
            r_s1_y    <= r_beam_y;
            r_s1_lend <= last_px;
            r_s1_fend <= last_px && last_ln;
        end
        if (s1_adv) begin
            r_s2_tile <= r_s1_tile;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_lend <= r_s1_lend;
            r_s2_fend <= r_s1_fend;
        end
        if (o_adv) begin
            r_o_rgb  <= r_s2_row[3'd7 - r_s2_x[2:0]] ? fg : RGB_BLACK;
            r_o_x    <= r_s2_x;
            r_o_y    <= r_s2_y;
            r_o_lend <= r_s2_lend;
            r_o_fend <= r_s2_fend;
        end
    end

    assign o_pix.valid     = r_o_valid;
    assign o_pix.red       = r_o_rgb.red;
    assign o_pix.green     = r_o_rgb.green;
    assign o_pix.blue      = r_o_rgb.blue;
    assign o_pix.pixel_x   = r_o_x;
    assign o_pix.pixel_y   = r_o_y;
    assign o_pix.line_end  = r_o_lend;
    assign o_pix.frame_end = r_o_fend;

`ifndef SYNTHESIS
    a_beam_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beam_x <= LAST_X) && (r_beam_y <= LAST_Y))
        else $error("beam left the raster");

    a_font_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        font_wr |-> (!r_s1_valid || s1_adv))
        else $error("font write passed a pending font read");

    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !req_acc)
        else $error("request taken during clearing pass");

    a_pix_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> r_s1_valid)
        else $error("accepted pixel lost at stage one");

    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_fend) |-> (r_o_lend && (r_o_y == LAST_Y)))
        else $error("frame end off the last line end");
`endif

endmodule

// ----- test/ttvg_pixel_monitor.sv -----
// Pixel monitor: mirrors the character map, font store and beam, predicts every pixel, compares.
module ttvg_pixel_monitor #(
    parameter int TILE_COLUMNS = ttvg_pkg::DEF_TILE_COLUMNS,
    parameter int SCAN_LINES   = ttvg_pkg::DEF_SCAN_LINES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ttvg_in_if   i_req,
    ttvg_out_if  i_pix,
    output int   o_fail_count,
    output int   o_pending
);
    import ttvg_pkg::*;

    localparam int TILE_ROWS   = (SCAN_LINES + 7) / 8;
    localparam int MAP_CELLS   = TILE_COLUMNS * TILE_ROWS;
    localparam int LINE_PIXELS = TILE_COLUMNS * 8;
    localparam int FONT_BASE   = 32'hF000;
    localparam int MAP_BASE    = 32'hF800;

    localparam t_rgb FG_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam t_rgb BG_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam t_rgb FG_PALETTE [6] = '{
        '{red: 8'd0,   green: 8'd255, blue: 8'd0},
        '{red: 8'd255, green: 8'd0,   blue: 8'd0},
        '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
        '{red: 8'd255, green: 8'd255, blue: 8'd0},
        '{red: 8'd0,   green: 8'd255, blue: 8'd255},
        '{red: 8'd255, green: 8'd0,   blue: 8'd255}
    };

    typedef struct packed {
        t_rgb           color;
        logic [8:0]     px;
        logic [7:0]     py;
        logic           line_end;
        logic           frame_end;
    } t_raster_pixel;

    logic [7:0]    tile_map [MAP_CELLS];
    logic [7:0]    glyph_rows [FONT_CELLS];
    int            beam_x;
    int            beam_y;
    int            failures = 0;
    t_raster_pixel expected_pixels [$];

    function automatic void store_write(input logic [15:0] addr, input logic [7:0] data);
        int a;
        a = int'(addr);
        if (a >= FONT_BASE && a < FONT_BASE + FONT_CELLS) begin
            glyph_rows[a - FONT_BASE] = data;
        end else if (a >= MAP_BASE && a < MAP_BASE + MAP_CELLS) begin
            tile_map[a - MAP_BASE] = data;
        end
    endfunction

    // Pixel under the beam, then the beam moves on in raster order.
    function automatic t_raster_pixel render_pixel();
        t_raster_pixel p;
        int            x;
        int            y;
        int            map_pos;
        logic [7:0]    tile;
        logic [7:0]    glyph;
        x = beam_x;
        y = beam_y;
        if (x >= LINE_PIXELS) x = 0;
        if (y >= SCAN_LINES) y = 0;
        map_pos = (y / 8) * TILE_COLUMNS + x / 8;
        tile    = (map_pos < MAP_CELLS) ? tile_map[map_pos] : 8'd0;
        glyph   = glyph_rows[(int'(tile) * 8 + y % 8) % FONT_CELLS];
        if (glyph[7 - x % 8]) begin
            if (tile >= 8'd8 && tile < 8'd32) begin
                p.color = FG_PALETTE[(int'(tile) - 8) % 6];
            end else begin
                p.color = FG_WHITE;
            end
        end else begin
            p.color = BG_BLACK;
        end
        p.px        = 9'(x);
        p.py        = 8'(y);
        p.line_end  = (x == LINE_PIXELS - 1);
        p.frame_end = p.line_end && (y == SCAN_LINES - 1);
        if (p.line_end) begin
            beam_x = 0;
            beam_y = p.frame_end ? 0 : y + 1;
        end else begin
            beam_x = x + 1;
            beam_y = y;
        end
        return p;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("pixel field %s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_raster_pixel want;
        t_raster_pixel got;
        t_raster_pixel next_px;
        if (!i_rst_n) begin
            foreach (tile_map[i]) tile_map[i] = 8'd0;
            foreach (glyph_rows[i]) glyph_rows[i] = 8'd0;
            beam_x = 0;
            beam_y = 0;
            expected_pixels.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                got.color.red   = i_pix.red;
                got.color.green = i_pix.green;
                got.color.blue  = i_pix.blue;
                got.px          = i_pix.pixel_x;
                got.py          = i_pix.pixel_y;
                got.line_end    = i_pix.line_end;
                got.frame_end   = i_pix.frame_end;
                if (expected_pixels.size() == 0) begin
                    $error("pixel at x=%0d y=%0d with no tick outstanding", got.px, got.py);
                    failures++;
                end else begin
                    want = expected_pixels[0];
                    expected_pixels.delete(0);
                    check_field("red", want.color.red, got.color.red);
                    check_field("green", want.color.green, got.color.green);
                    check_field("blue", want.color.blue, got.color.blue);
                    check_field("pixel_x", want.px, got.px);
                    check_field("pixel_y", want.py, got.py);
                    check_field("line_end", want.line_end, got.line_end);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.func == FUNC_WRITE) begin
                    store_write(i_req.address, i_req.write_data);
                end else begin
                    next_px = render_pixel();
                    expected_pixels.insert(expected_pixels.size(), next_px);
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= failures;
    end

endmodule

// ----- test/tb_tile_text_video_generator_core.sv -----
// Testbench top: drives writes and pixel ticks into the video generator and gives the verdict.
module tb_tile_text_video_generator_core;
    import ttvg_pkg::*;

    localparam int TILE_COLUMNS   = DEF_TILE_COLUMNS;
    localparam int SCAN_LINES     = DEF_SCAN_LINES;
    localparam int TILE_ROWS      = (SCAN_LINES + 7) / 8;
    localparam int MAP_CELLS      = TILE_COLUMNS * TILE_ROWS;
    localparam int LINE_PIXELS    = TILE_COLUMNS * 8;
    localparam int FRAME_PIXELS   = LINE_PIXELS * SCAN_LINES;
    localparam int FONT_BASE      = 32'hF000;
    localparam int MAP_BASE       = 32'hF800;
    localparam int PHASE_REQUESTS = 160;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttvg_in_if  req_if ();
    ttvg_out_if pix_if ();

    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_request = 1'b0;
    int         ticks_sent = 0;
    int         idle_cycles = 0;
    logic [7:0] last_tile = 8'd0;

    always #5 i_clk = ~i_clk;

    tile_text_video_generator_core #(
        .TILE_COLUMNS(TILE_COLUMNS),
        .SCAN_LINES  (SCAN_LINES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_pix  (pix_if)
    );

    ttvg_pixel_monitor #(
        .TILE_COLUMNS(TILE_COLUMNS),
        .SCAN_LINES  (SCAN_LINES)
    ) u_pixel_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_pix       (pix_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Pixel receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int held;
        pix_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (held = 0; held < LONG_HOLD; held++) begin
                    pix_if.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            pix_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tile_text_video_generator_core verification failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic func, input logic [15:0] addr,
                                input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.address    <= addr;
        req_if.write_data <= data;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (func == FUNC_PIXEL) ticks_sent++;
    endtask

    task automatic send_tick();
        send_request(FUNC_PIXEL, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
    endtask

    // Sender pause until every pixel has come back.
    task automatic drain_pixels();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_tile();
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 40));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ticks, map writes just ahead of the beam, glyph rows it will hit and writes to random addresses.
    task automatic random_request();
        int         choice;
        int         beam;
        int         map_pos;
        int         row;
        logic [7:0] tile;
        choice  = $urandom_range(0, 99);
        beam    = ticks_sent % FRAME_PIXELS;
        row     = (beam / LINE_PIXELS) % 8;
        map_pos = (beam / LINE_PIXELS / 8) * TILE_COLUMNS + (beam % LINE_PIXELS) / 8;
        if (choice < 55) begin
            send_tick();
        end else if (choice < 75) begin
            tile      = pick_tile();
            last_tile = tile;
            map_pos   = map_pos + $urandom_range(0, 2);
            if (map_pos >= MAP_CELLS) map_pos = $urandom_range(0, MAP_CELLS - 1);
            send_request(FUNC_WRITE, 16'(MAP_BASE + map_pos), tile);
        end else if (choice < 90) begin
            tile = ($urandom_range(0, 99) < 60) ? last_tile : pick_tile();
            if ($urandom_range(0, 99) >= 70) row = $urandom_range(0, 7);
            send_request(FUNC_WRITE, 16'(FONT_BASE + int'(tile) * 8 + row),
                         8'($urandom_range(0, 255)));
        end else begin
            send_request(FUNC_WRITE, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int n;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_PIXEL;
        req_if.address    = 16'h0000;
        req_if.write_data = 8'h00;
        i_rst_n           = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 75;

        // directed: cleared stores, palette and white tiles, store edges, dropped writes
        send_tick();
        send_request(FUNC_WRITE, 16'hF000, 8'hFF);
        send_tick();
        send_request(FUNC_WRITE, 16'hF800, 8'd8);
        send_request(FUNC_WRITE, 16'hF040, 8'hA5);
        send_tick();
        send_request(FUNC_WRITE, 16'hF801, 8'd31);
        send_request(FUNC_WRITE, 16'hF0F8, 8'hFF);
        send_request(FUNC_WRITE, 16'hFCAF, 8'd255);
        send_request(FUNC_WRITE, 16'hFCB0, 8'hFF);
        send_request(FUNC_WRITE, 16'hEFFF, 8'hFF);
        send_request(FUNC_WRITE, 16'hF7FF, 8'h80);
        send_request(FUNC_WRITE, 16'hFFFF, 8'hFF);
        send_request(FUNC_WRITE, 16'h0000, 8'h00);
        for (n = 0; n < 9; n++) send_tick();

        for (n = 0; n < PHASE_REQUESTS; n++) random_request();
        drain_pixels();

        send_idle_pct = 75;
        recv_idle_pct = 21;
        for (n = 0; n < PHASE_REQUESTS; n++) random_request();
        drain_pixels();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (n = 0; n < PHASE_REQUESTS; n++) random_request();
        drain_pixels();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tile_text_video_generator_core verification clean");
        end else begin
            $display("tile_text_video_generator_core verification failed");
        end
        $finish;
    end

endmodule
